// ----- rtl/spq_pkg.sv -----
// ============================================================================
// Sorted priority queue package
// Sizes, entry layout and command and status codes shared by the queue files.
// ============================================================================
package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 16;

    localparam int KEY_W      = 32;
    localparam int PAY_PORT_W = 16;
    localparam int PAY_W      = (PAYLOAD_BITS < PAY_PORT_W) ? PAYLOAD_BITS : PAY_PORT_W;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OCC_W      = 5;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] pay;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/spq_ram.sv -----
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sorted_priority_queue_unit.sv -----
// ============================================================================
// Sorted priority queue unit
// Bounded queue kept in ascending key order in one RAM, with equal keys
// leaving first in, first out; a small sequencer moves one entry at a time.
// ============================================================================
//
// Channel   Dir  Handshake          Contents
// s_        in   s_tvalid/s_tready  tuser: command; tdata: key, payload
// m_        out  m_tvalid/m_tready  tuser: status; tdata: key, payload, occupancy, empty
//
// An enqueue moves every stored entry with a larger key up one slot, and a
// dequeue reads all stored entries and moves each after the first down one
// slot; each entry moved costs one RAM read and one write.
// Reset clears the sequencer, the entry count and the output valid flag only.
// A new word is taken while a result still waits in the output register; the
// next result then holds the sequencer in its last step until that one leaves.
module sorted_priority_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key [31:0], payload [47:32]
    input  logic [1:0]  s_tuser,   // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_key [31:0], out_payload [47:32],
                                   // occupancy [52:48], is_empty [53], zero [55:54]
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ENQ_RD = 3'd1;
    localparam logic [2:0] ST_ENQ_WR = 3'd2;
    localparam logic [2:0] ST_DEQ_RD = 3'd3;
    localparam logic [2:0] ST_DEQ_MV = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [spq_pkg::CNT_W-1:0] count_reg, count_next;
    logic [spq_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic signed [spq_pkg::KEY_W-1:0] key_reg, key_next;
    logic [spq_pkg::PAY_W-1:0] pay_reg, pay_next;
    logic [1:0] res_status_reg, res_status_next;
    logic signed [spq_pkg::KEY_W-1:0] res_key_reg, res_key_next;
    logic [spq_pkg::PAY_W-1:0] res_pay_reg, res_pay_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [31:0] m_key_reg, m_key_next;
    logic [15:0] m_pay_reg, m_pay_next;
    logic [spq_pkg::OCC_W-1:0] m_occ_reg, m_occ_next;
    logic        m_empty_reg, m_empty_next;

    logic                       wr_en;
    logic [spq_pkg::ADDR_W-1:0] wr_addr;
    spq_pkg::entry_t            wr_entry;
    logic [spq_pkg::ADDR_W-1:0] rd_addr;
    spq_pkg::entry_t            rd_entry;
    logic [spq_pkg::ENTRY_W-1:0] rd_data;
    logic [spq_pkg::CNT_W-1:0]  idx_dec;
    logic                       out_free;

    assign rd_entry = spq_pkg::entry_t'(rd_data);

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (spq_pkg::DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_dec  = idx_reg - spq_pkg::CNT_W'(1);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[spq_pkg::ADDR_W-1:0];
        wr_entry.key    = key_reg;
        wr_entry.pay    = pay_reg;
        rd_addr         = idx_reg[spq_pkg::ADDR_W-1:0];

        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_key_next    = m_key_reg;
        m_pay_next    = m_pay_reg;
        m_occ_next    = m_occ_reg;
        m_empty_next  = m_empty_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next        = $signed(s_tdata[31:0]);
                    pay_next        = s_tdata[32 +: spq_pkg::PAY_W];
                    res_status_next = spq_pkg::STATUS_OK;
                    res_key_next    = '0;
                    res_pay_next    = '0;
                    idx_next        = '0;
                    state_next      = ST_FIN;
                    case (s_tuser)
                        spq_pkg::CMD_ENQUEUE: begin
                            if (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                                res_status_next = spq_pkg::STATUS_FULL;
                            end else begin
                                idx_next   = count_reg;
                                state_next = ST_ENQ_RD;
                            end
                        end
                        spq_pkg::CMD_DEQUEUE: begin
                            if (count_reg == '0) begin
                                res_status_next = spq_pkg::STATUS_EMPTY;
                            end else begin
                                state_next = ST_DEQ_RD;
                            end
                        end
                        spq_pkg::CMD_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENQ_RD: begin
                if (idx_reg == '0) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                    state_next = ST_FIN;
                end else begin
                    rd_addr    = idx_dec[spq_pkg::ADDR_W-1:0];
                    state_next = ST_ENQ_WR;
                end
            end
            ST_ENQ_WR: begin
                wr_en = 1'b1;
                if (rd_entry.key > key_reg) begin
                    wr_entry   = rd_entry;
                    idx_next   = idx_dec;
                    state_next = ST_ENQ_RD;
                end else begin
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                    state_next = ST_FIN;
                end
            end
            ST_DEQ_RD: begin
                state_next = ST_DEQ_MV;
            end
            ST_DEQ_MV: begin
                if (idx_reg == '0) begin
                    res_key_next = rd_entry.key;
                    res_pay_next = rd_entry.pay;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_dec[spq_pkg::ADDR_W-1:0];
                    wr_entry = rd_entry;
                end
                idx_next = idx_reg + spq_pkg::CNT_W'(1);
                if (idx_next == count_reg) begin
                    count_next = count_reg - spq_pkg::CNT_W'(1);
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DEQ_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_key_next    = res_key_reg;
                    m_pay_next    = 16'(res_pay_reg);
                    m_occ_next    = spq_pkg::OCC_W'(count_reg);
                    m_empty_next  = (count_reg == '0);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_pay_reg      <= m_pay_next;
        m_occ_reg      <= m_occ_next;
        m_empty_reg    <= m_empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_empty_reg, m_occ_reg, m_pay_reg, m_key_reg};

endmodule

// ----- tb/sorted_priority_queue_checker.sv -----
// ============================================================================
// Sorted priority queue checker
// Watches both stream channels of the queue, keeps its own sorted copy of
// the stored entries, predicts the reply to every accepted word and compares
// each returned word field by field with the oldest pending prediction.
// ============================================================================
module sorted_priority_queue_checker
    import spq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // key [31:0], payload [47:32]
    input  logic [1:0]  s_tuser,   // command [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // out_key [31:0], out_payload [47:32],
                                   // occupancy [52:48], is_empty [53], zero [55:54]
    input  logic [1:0]  m_tuser,   // status [1:0]
    output int          error_count,
    output int          awaited,
    output int          words_checked,
    output int          full_rejects,
    output int          empty_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        tag;
        logic [OCC_W-1:0]        occupancy;
        logic                    empty;
    } queue_reply_t;

    logic signed [KEY_W-1:0] sorted_keys [DEPTH];
    logic [PAY_W-1:0]        sorted_tags [DEPTH];
    int                      stored;
    queue_reply_t            pending_replies [$];

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic queue_reply_t predict_queue_op(input logic [1:0] cmd,
                                                      input logic signed [KEY_W-1:0] key,
                                                      input logic [PAY_W-1:0] tag);
        queue_reply_t r;
        int           pos;
        r.status = STATUS_OK;
        r.key    = '0;
        r.tag    = '0;
        case (cmd)
            CMD_ENQUEUE: begin
                if (stored >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    pos = 0;
                    while (pos < stored && sorted_keys[pos] <= key)
                        pos++;
                    for (int i = stored; i > pos; i--) begin
                        sorted_keys[i] = sorted_keys[i-1];
                        sorted_tags[i] = sorted_tags[i-1];
                    end
                    sorted_keys[pos] = key;
                    sorted_tags[pos] = tag;
                    stored++;
                end
            end
            CMD_DEQUEUE: begin
                if (stored == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.key = sorted_keys[0];
                    r.tag = sorted_tags[0];
                    for (int i = 1; i < stored; i++) begin
                        sorted_keys[i-1] = sorted_keys[i];
                        sorted_tags[i-1] = sorted_tags[i];
                    end
                    stored--;
                end
            end
            CMD_CLEAR: begin
                stored = 0;
            end
            default: begin
            end
        endcase
        r.occupancy = OCC_W'(stored);
        r.empty     = (stored == 0);
        return r;
    endfunction

    always @(posedge aclk) begin
        queue_reply_t want;
        if (!aresetn) begin
            stored = 0;
            pending_replies.delete();
            error_count   = 0;
            words_checked = 0;
            full_rejects  = 0;
            empty_rejects = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                want = predict_queue_op(s_tuser, s_tdata[31:0], s_tdata[47:32]);
                if (want.status == STATUS_FULL)
                    full_rejects++;
                if (want.status == STATUS_EMPTY)
                    empty_rejects++;
                pending_replies.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    report($sformatf("result word with no command waiting: %h %h",
                                     m_tuser, m_tdata));
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tuser !== want.status)
                        report($sformatf("word %0d status %0d, expected %0d",
                                         words_checked, m_tuser, want.status));
                    if (m_tdata[31:0] !== want.key)
                        report($sformatf("word %0d key %0d, expected %0d", words_checked,
                                         $signed(m_tdata[31:0]), want.key));
                    if (m_tdata[47:32] !== want.tag)
                        report($sformatf("word %0d payload %h, expected %h",
                                         words_checked, m_tdata[47:32], want.tag));
                    if (m_tdata[52:48] !== want.occupancy)
                        report($sformatf("word %0d occupancy %0d, expected %0d",
                                         words_checked, m_tdata[52:48], want.occupancy));
                    if (m_tdata[53] !== want.empty)
                        report($sformatf("word %0d empty flag %b, expected %b",
                                         words_checked, m_tdata[53], want.empty));
                    if (m_tdata[55:54] !== 2'b00)
                        report($sformatf("word %0d pad bits %b, expected 00",
                                         words_checked, m_tdata[55:54]));
                    words_checked++;
                end
            end
        end
        awaited = pending_replies.size();
    end

endmodule

// ----- tb/sorted_priority_queue_unit_tb.sv -----
// ============================================================================
// Sorted priority queue unit testbench
// Drives directed and random enqueue, dequeue, clear and unused commands with
// random gaps and receiver stalls, including one long output stall that
// backs the queue up; a separate checker predicts and compares every reply.
// ============================================================================
module sorted_priority_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam logic [1:0]              CMD_NOP      = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN      = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX      = 32'sh7fff_ffff;
    localparam int                      RANDOM_WORDS = 1750;
    localparam int                      LONG_HOLD    = 300;
    localparam int                      DRAIN_LIMIT  = 20000;
    localparam int                      SETTLE       = 2 * DEPTH + 8;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    int error_count;
    int awaited;
    int words_checked;
    int full_rejects;
    int empty_rejects;

    bit no_idle;
    bit hold_output;
    int cmd_seen [4];

    sorted_priority_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sorted_priority_queue_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .awaited       (awaited),
        .words_checked (words_checked),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("ERROR: run did not finish in time");
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: a random stall before each word, or one long stall on request.
    initial begin
        int stall;
        bit long_done;
        m_tready  = 1'b0;
        long_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_output && !long_done) begin
                stall     = LONG_HOLD;
                long_done = 1'b1;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic signed [KEY_W-1:0] key,
                             input logic [PAY_W-1:0] tag);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {tag, key};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        cmd_seen[cmd]++;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(input int style);
        case (style)
            0: return $urandom_range(0, 7) - 4;
            1: return $urandom();
            default: begin
                case ($urandom_range(0, 5))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return 0;
                    3: return -1;
                    4: return $urandom_range(0, 3) - 2;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    function automatic logic [1:0] pick_command(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return CMD_CLEAR;
        if (roll < 5)
            return CMD_NOP;
        case (mode)
            0: return (roll < 80) ? CMD_ENQUEUE : CMD_DEQUEUE;
            1: return (roll < 30) ? CMD_ENQUEUE : CMD_DEQUEUE;
            default: return (roll < 53) ? CMD_ENQUEUE : CMD_DEQUEUE;
        endcase
    endfunction

    initial begin
        int sent;
        int mode;
        int style;
        int len;
        int drain;
        int leftover;
        sent     = 0;
        leftover = 0;
        no_idle     = 1'b0;
        hold_output = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ENQUEUE;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        send_word(CMD_DEQUEUE, 0, 16'h0000);
        send_word(CMD_NOP, KEY_MAX, 16'hffff);
        send_word(CMD_CLEAR, KEY_MIN, 16'hffff);
        send_word(CMD_ENQUEUE, KEY_MAX, 16'hffff);
        send_word(CMD_ENQUEUE, KEY_MIN, 16'h0000);
        send_word(CMD_ENQUEUE, 0, 16'h0001);
        send_word(CMD_ENQUEUE, -1, 16'h8000);
        send_word(CMD_ENQUEUE, 0, 16'h0002);
        send_word(CMD_ENQUEUE, 0, 16'h0003);
        send_word(CMD_DEQUEUE, KEY_MAX, 16'hffff);
        send_word(CMD_DEQUEUE, 0, 16'h0000);
        for (int i = 0; i < 12; i++)
            send_word(CMD_ENQUEUE, (i % 3) - 1, 16'(16'h1000 + i));
        send_word(CMD_ENQUEUE, KEY_MIN, 16'h5555);
        send_word(CMD_CLEAR, 0, 16'h0000);

        // Long output stall while words keep coming, so the queue backs up.
        hold_output = 1'b1;
        no_idle     = 1'b1;
        repeat (40) begin
            send_word(pick_command(0), pick_key(1), PAY_W'($urandom()));
            sent++;
        end

        while (sent < RANDOM_WORDS) begin
            mode    = $urandom_range(0, 2);
            style   = $urandom_range(0, 2);
            no_idle = ($urandom_range(0, 3) == 0);
            len     = $urandom_range(20, 120);
            if (len > RANDOM_WORDS - sent)
                len = RANDOM_WORDS - sent;
            repeat (len) begin
                send_word(pick_command(mode), pick_key(style), PAY_W'($urandom()));
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (awaited != 0 && drain < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain++;
        end
        if (awaited != 0) begin
            leftover = awaited;
            $display("ERROR: %0d result words never arrived", leftover);
        end
        repeat (SETTLE) @(negedge aclk);

        $display("Run sent %0d enqueue, %0d dequeue, %0d clear and %0d unused-code words;",
                 cmd_seen[CMD_ENQUEUE], cmd_seen[CMD_DEQUEUE], cmd_seen[CMD_CLEAR],
                 cmd_seen[CMD_NOP]);
        $display("%0d replies checked, %0d full-queue rejects, %0d empty-queue dequeues.",
                 words_checked, full_rejects, empty_rejects);
        if (error_count == 0 && leftover == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
